// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define BBSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define BBSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bbss_pkg.sv
// Shared types and constants of the box blur sharpen block.
package bbss_pkg;

   localparam int ROW_W      = 13;
   localparam int MAX_HEIGHT = 4096;

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GAIN_Q8      = 2'd2;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CALC,
      ST_DECIDE,
      ST_SUM,
      ST_SRC,
      ST_DIV1,
      ST_DIV2,
      ST_MUL,
      ST_FIN
   } state_type;

endpackage

// File: hw/rtl/bbss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bbss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 5632
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bbss_addr.sv
// Window read address: reflect-101 row/column mirroring and line slot mapping.
module bbss_addr #(
   parameter int MAX_WIDTH = 512,
   parameter int WINDOW    = 11
) (
   input  logic [bbss_pkg::ROW_W-1:0]         out_row,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]     out_col,
   input  logic [$clog2(WINDOW)-1:0]          out_slot,
   input  logic [$clog2(WINDOW)-1:0]          win_r,
   input  logic [$clog2(WINDOW)-1:0]          win_c,
   input  logic                               sel_src,
   input  logic [bbss_pkg::ROW_W-1:0]         h,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]     w,
   output logic [$clog2(WINDOW*MAX_WIDTH)-1:0] addr
);

   localparam int PAD = (WINDOW - 1) / 2;
   localparam int RW  = bbss_pkg::ROW_W;
   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int SW  = $clog2(WINDOW);
   localparam int AW  = $clog2(WINDOW * MAX_WIDTH);
   localparam logic signed [RW+1:0] PAD_R = (RW+2)'(PAD);
   localparam logic signed [CW+1:0] PAD_C = (CW+2)'(PAD);
   localparam logic signed [SW+1:0] WIN_S = (SW+2)'(WINDOW);

   logic signed [RW+1:0] xr, rr, dl;
   logic signed [CW+1:0] xc, cc;
   logic signed [SW+1:0] st;
   logic [SW-1:0]        slot;
   logic [CW-1:0]        col;

   always_comb begin
      // row: mirror about the top and bottom edges
      xr = $signed((RW+2)'(out_row)) + $signed((RW+2)'(win_r)) - PAD_R;
      if (xr < 0) begin
         rr = -xr;
      end else if (xr >= $signed((RW+2)'(h))) begin
         rr = $signed((RW+2)'(h) << 1) - (RW+2)'(2) - xr;
      end else begin
         rr = xr;
      end
      // row offset stays within one window, so one correction maps the slot
      dl = rr - $signed((RW+2)'(out_row));
      st = $signed((SW+2)'(out_slot)) + $signed(dl[SW+1:0]);
      if (st < 0) begin
         st = st + WIN_S;
      end else if (st >= WIN_S) begin
         st = st - WIN_S;
      end
      // column: mirror about the left and right edges
      xc = $signed((CW+2)'(out_col)) + $signed((CW+2)'(win_c)) - PAD_C;
      if (xc < 0) begin
         cc = -xc;
      end else if (xc >= $signed((CW+2)'(w))) begin
         cc = $signed((CW+2)'(w) << 1) - (CW+2)'(2) - xc;
      end else begin
         cc = xc;
      end
      if (sel_src) begin
         slot = out_slot;
         col  = out_col;
      end else begin
         slot = st[SW-1:0];
         col  = cc[CW-1:0];
      end
      addr = AW'(AW'(slot) * AW'(MAX_WIDTH)) + AW'(col);
   end

endmodule

// File: hw/rtl/box_blur_subtract_sharpen.sv
// Top level: streaming 2-D box blur with unsharp subtraction.
//
// Usage notes
//   req channel (req_valid / req_stall): one transfer per pixel in raster
//     order (req_type = pixel) or a drain tick (req_type = drain) after the
//     last pixel of a frame to flush the trailing results.
//   rsp channel (rsp_valid / rsp_stall): sharp pixel, box mean and a
//     frame_last flag on the final result of the frame. Results lag the input
//     by (WINDOW-1)/2 rows plus (WINDOW-1)/2 pixels.
//   csr channel (csr_valid / csr_ready): index 0 width, 1 height, 2 gain.
//     csr_ready is always high; write only while the block is idle.
//   Sequencing: one item at a time. An item with no result passes CALC and
//     DECIDE and returns to idle. An item with a result then gathers the box
//     sum one line-store read per cycle over the single read port (SUM), reads
//     the source pixel (SRC), then a reciprocal divide and gain multiply follow.
//   The result sits in an output register, so a new item is taken while the
//     previous result waits; a stalled receiver only holds the block at its
//     final step when a second result is ready.
//   Reset (synchronous): counters clear, registers return to 512/512/77.
//     The line store is not cleared; entries are written before being read.
module box_blur_subtract_sharpen #(
   parameter int MAX_WIDTH      = 512,
   parameter int WINDOW         = 11,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_sharp_pixel,
   output logic [7:0]  rsp_blurred_pixel,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

`include "assert_macros.svh"

   localparam int PAD    = (WINDOW - 1) / 2;
   localparam int RW     = bbss_pkg::ROW_W;
   localparam int CW     = $clog2(MAX_WIDTH + 1);
   localparam int WXW    = (CW > 10) ? CW : 10;
   localparam int SW     = $clog2(WINDOW);
   localparam int DEPTH  = WINDOW * MAX_WIDTH;
   localparam int AW     = $clog2(DEPTH);
   localparam int PW     = CW + RW;
   localparam int NN     = WINDOW * WINDOW;
   localparam int SUMW   = $clog2(NN * 255 + 1);
   localparam int RECIP  = (1 << SUMW) / NN;
   localparam int RECIPH = (1 << RW) / WINDOW;
   localparam int F      = GAIN_FRAC_BITS;
   localparam int XW     = ((8 + F) > 17) ? (8 + F + 1) : 18;

   // configuration
   logic [9:0]  image_width_ff;
   logic [12:0] image_height_ff;
   logic [8:0]  gain_q8_ff;
   logic [RW-1:0] hq;
   logic [SW-1:0] hmod;

   // frame position
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SW-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;

   bbss_pkg::state_type state_ff, state_in;

   logic [PW-1:0]   n_ff, n_in, o_ff, o_in, total_ff, total_in, lag_ff, lag_in;
   logic            last_ff, last_in;
   logic [SW-1:0]   win_r_ff, win_r_in, win_c_ff, win_c_in;
   logic            acc_ff, acc_in;
   logic [SUMW-1:0] sum_ff, sum_in, q0_ff, q0_in;
   logic [7:0]      src_ff, src_in, mean_ff, mean_in;
   logic [16:0]     gprod_ff, gprod_in;

   logic       rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [7:0] rsp_sharp_ff, rsp_sharp_in, rsp_mean_ff, rsp_mean_in;

   // derived sizes
   logic [WXW-1:0] w_raw;
   logic [CW-1:0]  w;
   logic [RW-1:0]  h;

   // accept-time position update
   logic [RW-1:0] ir_n, or_n, ir_w;
   logic [CW-1:0] ic_n, oc_n, ic_w;
   logic [SW-1:0] is_n, os_n, is_w;
   logic          end_frame, do_write, accept;

   // memory side
   logic          rd_en, sel_src;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    rd_data;

   // arithmetic helpers
   logic [2*RW-1:0]   hprod;
   logic [RW-1:0]     hrem;
   logic [2*SUMW-1:0] mprod;
   logic [SUMW-1:0]   mrem, mq;
   logic [XW-1:0]     sa, sb, sd;
   logic [XW-1:0]     sharp_v;
   logic [PW:0]       gap;
   logic              due, load;

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      slot_inc = (s == SW'(WINDOW - 1)) ? '0 : s + SW'(1);
   endfunction

   assign csr_ready = 1'b1;

   // size clamps
   always_comb begin
      w_raw = WXW'(image_width_ff);
      if (w_raw < WXW'(WINDOW)) begin
         w = CW'(WINDOW);
      end else if (w_raw > WXW'(MAX_WIDTH)) begin
         w = CW'(MAX_WIDTH);
      end else begin
         w = CW'(w_raw);
      end
      if (image_height_ff < 13'(WINDOW)) begin
         h = RW'(WINDOW);
      end else if (image_height_ff > 13'(bbss_pkg::MAX_HEIGHT)) begin
         h = RW'(bbss_pkg::MAX_HEIGHT);
      end else begin
         h = RW'(image_height_ff);
      end
   end

   // height modulo WINDOW by reciprocal multiply, used when the row clamps
   always_comb begin
      hprod = (2*RW)'(h) * (2*RW)'(RECIPH);
      hq    = RW'(hprod >> RW);
      hrem  = h - RW'(hq * RW'(WINDOW));
      hmod  = (hrem >= RW'(WINDOW)) ? SW'(hrem - RW'(WINDOW)) : SW'(hrem);
   end

   // position bookkeeping for the accepted item
   always_comb begin
      ic_n = in_col_ff;
      ir_n = in_row_ff;
      is_n = in_slot_ff;
      if (ic_n >= w) begin
         ic_n = '0;
         ir_n = ir_n + RW'(1);
         is_n = slot_inc(is_n);
      end
      if (ir_n > h) begin
         ir_n = h;
         ic_n = '0;
         is_n = hmod;
      end
      oc_n = out_col_ff;
      or_n = out_row_ff;
      os_n = out_slot_ff;
      if (oc_n >= w) begin
         oc_n = '0;
         or_n = or_n + RW'(1);
         os_n = slot_inc(os_n);
      end
      end_frame = (or_n >= h);
      do_write  = accept && !end_frame && (req_type == bbss_pkg::REQ_PIXEL) && (ir_n < h);
      ic_w = ic_n;
      ir_w = ir_n;
      is_w = is_n;
      if (do_write) begin
         ic_w = ic_n + CW'(1);
         if (ic_w >= w) begin
            ic_w = '0;
            ir_w = ir_n + RW'(1);
            is_w = slot_inc(is_n);
         end
      end
      wr_addr = AW'(AW'(is_n) * AW'(MAX_WIDTH)) + AW'(ic_n);
   end

   assign req_stall = (state_ff != bbss_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   bbss_addr #(
      .MAX_WIDTH (MAX_WIDTH),
      .WINDOW    (WINDOW)
   ) u_addr (
      .out_row  (out_row_ff),
      .out_col  (out_col_ff),
      .out_slot (out_slot_ff),
      .win_r    (win_r_ff),
      .win_c    (win_c_ff),
      .sel_src  (sel_src),
      .h        (h),
      .w        (w),
      .addr     (rd_addr)
   );

   // line store; writes happen only at accept and reads only in later
   // steps of the same item, so the two ports never touch one entry at once
   bbss_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // datapath helpers
   always_comb begin
      gap   = (PW+1)'(n_ff) - (PW+1)'(o_ff);
      due   = ((n_ff >= total_ff) && (o_ff < n_ff)) ||
              (!gap[PW] && (gap > (PW+1)'(lag_ff)));
      mprod = (2*SUMW)'(sum_ff) * (2*SUMW)'(RECIP);
      mrem  = sum_ff - SUMW'(q0_ff * SUMW'(NN));
      mq    = (mrem >= SUMW'(NN)) ? q0_ff + SUMW'(1) : q0_ff;
      sa    = XW'(src_ff) << F;
      sb    = XW'(gprod_ff);
      sd    = sa - sb;
      if (sa <= sb) begin
         sharp_v = '0;
      end else if ((sd >> F) > XW'(255)) begin
         sharp_v = XW'(255);
      end else begin
         sharp_v = sd >> F;
      end
   end

   // sequencer: next state and register updates
   always_comb begin
      state_in    = state_ff;
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_slot_in  = in_slot_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_slot_in = out_slot_ff;
      n_in        = n_ff;
      o_in        = o_ff;
      total_in    = total_ff;
      lag_in      = lag_ff;
      last_in     = last_ff;
      win_r_in    = win_r_ff;
      win_c_in    = win_c_ff;
      acc_in      = 1'b0;
      sum_in      = acc_ff ? sum_ff + SUMW'(rd_data) : sum_ff;
      q0_in       = q0_ff;
      src_in      = src_ff;
      mean_in     = mean_ff;
      gprod_in    = gprod_ff;
      rd_en       = 1'b0;
      sel_src     = 1'b0;
      load        = 1'b0;
      unique case (state_ff)
         bbss_pkg::ST_IDLE: begin
            if (accept) begin
               if (end_frame) begin
                  in_row_in   = '0;
                  in_col_in   = '0;
                  in_slot_in  = '0;
                  out_row_in  = '0;
                  out_col_in  = '0;
                  out_slot_in = '0;
               end else begin
                  in_row_in   = ir_w;
                  in_col_in   = ic_w;
                  in_slot_in  = is_w;
                  out_row_in  = or_n;
                  out_col_in  = oc_n;
                  out_slot_in = os_n;
                  state_in    = bbss_pkg::ST_CALC;
               end
            end
         end
         bbss_pkg::ST_CALC: begin
            n_in     = PW'(PW'(in_row_ff) * PW'(w)) + PW'(in_col_ff);
            o_in     = PW'(PW'(out_row_ff) * PW'(w)) + PW'(out_col_ff);
            total_in = PW'(PW'(w) * PW'(h));
            lag_in   = PW'(PW'(w) * PW'(PAD)) + PW'(PAD);
            state_in = bbss_pkg::ST_DECIDE;
         end
         bbss_pkg::ST_DECIDE: begin
            last_in  = (o_ff == total_ff - PW'(1));
            win_r_in = '0;
            win_c_in = '0;
            sum_in   = '0;
            state_in = due ? bbss_pkg::ST_SUM : bbss_pkg::ST_IDLE;
         end
         bbss_pkg::ST_SUM: begin
            rd_en  = 1'b1;
            acc_in = 1'b1;
            if (win_c_ff == SW'(WINDOW - 1)) begin
               win_c_in = '0;
               if (win_r_ff == SW'(WINDOW - 1)) begin
                  state_in = bbss_pkg::ST_SRC;
               end else begin
                  win_r_in = win_r_ff + SW'(1);
               end
            end else begin
               win_c_in = win_c_ff + SW'(1);
            end
         end
         bbss_pkg::ST_SRC: begin
            rd_en    = 1'b1;
            sel_src  = 1'b1;
            state_in = bbss_pkg::ST_DIV1;
         end
         bbss_pkg::ST_DIV1: begin
            src_in   = rd_data;
            q0_in    = SUMW'(mprod >> SUMW);
            state_in = bbss_pkg::ST_DIV2;
         end
         bbss_pkg::ST_DIV2: begin
            mean_in  = (mq > SUMW'(255)) ? 8'd255 : mq[7:0];
            state_in = bbss_pkg::ST_MUL;
         end
         bbss_pkg::ST_MUL: begin
            gprod_in = 17'(gain_q8_ff) * 17'(mean_ff);
            state_in = bbss_pkg::ST_FIN;
         end
         bbss_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = bbss_pkg::ST_IDLE;
               if (last_ff) begin
                  in_row_in   = '0;
                  in_col_in   = '0;
                  in_slot_in  = '0;
                  out_row_in  = '0;
                  out_col_in  = '0;
                  out_slot_in = '0;
               end else if (out_col_ff + CW'(1) >= w) begin
                  out_col_in  = '0;
                  out_row_in  = out_row_ff + RW'(1);
                  out_slot_in = slot_inc(out_slot_ff);
               end else begin
                  out_col_in  = out_col_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = bbss_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_sharp_in = rsp_sharp_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_sharp_in = sharp_v[7:0];
         rsp_mean_in  = mean_ff;
         rsp_last_in  = last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bbss_pkg::ST_IDLE;
         image_width_ff  <= 10'd512;
         image_height_ff <= 13'd512;
         gain_q8_ff      <= 9'd77;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         in_slot_ff      <= '0;
         out_row_ff      <= '0;
         out_col_ff      <= '0;
         out_slot_ff     <= '0;
         acc_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_slot_ff   <= in_slot_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_slot_ff  <= out_slot_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               bbss_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[9:0];
               bbss_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
               bbss_pkg::CSR_GAIN_Q8:      gain_q8_ff      <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      o_ff         <= o_in;
      total_ff     <= total_in;
      lag_ff       <= lag_in;
      last_ff      <= last_in;
      win_r_ff     <= win_r_in;
      win_c_ff     <= win_c_in;
      sum_ff       <= sum_in;
      q0_ff        <= q0_in;
      src_ff       <= src_in;
      mean_ff      <= mean_in;
      gprod_ff     <= gprod_in;
      rsp_sharp_ff <= rsp_sharp_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sharp_pixel   = rsp_sharp_ff;
   assign rsp_blurred_pixel = rsp_mean_ff;
   assign rsp_frame_last    = rsp_last_ff;

   `BBSS_ASSERT(a_load_shows, clock, reset, load |=> rsp_valid,
      "loaded result not presented")
   `BBSS_ASSERT(a_slot_range, clock, reset,
      (in_slot_ff < SW'(WINDOW)) && (out_slot_ff < SW'(WINDOW)),
      "line slot out of range")
   `BBSS_ASSERT(a_no_rw_overlap, clock, reset, !(do_write && rd_en),
      "line store written and read in the same cycle")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the box blur sharpen block: frame stimulus and pixel predictor.
`timescale 1ns / 100ps

module testbench;

   localparam int WIN   = 11;
   localparam int MAXW  = 512;
   localparam int FRAC  = 8;
   localparam int PAD   = (WIN - 1) / 2;
   localparam int LIMIT = 2_000_000;
   localparam int SETTLE = 200;   // longer than one result item takes

   typedef struct packed {
      logic [7:0] sharp;
      logic [7:0] blur;
      logic       last;
   } px_result_type;

   typedef enum int {ROW_CSR, ROW_XFER} row_kind_type;
   typedef enum int {CHK_PRED, CHK_TYPED, CHK_NONE} chk_type;

   typedef struct {
      row_kind_type  kind;
      logic          typ;
      int            val;     // pixel value or csr write data
      logic [1:0]    idx;
      int            cnt;
      bit            rnd;
      chk_type       chk;
      px_result_type typed;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = bbss_pkg::REQ_PIXEL;
   logic [7:0]  req_pixel_in = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_sharp_pixel;
   logic [7:0]  rsp_blurred_pixel;
   logic        rsp_frame_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = bbss_pkg::CSR_IMAGE_WIDTH;
   logic [12:0] csr_wdata = 13'd0;

   box_blur_subtract_sharpen u_top (.*);

   // predictor state
   logic [7:0]  line_mem [0:WIN*MAXW-1];
   int unsigned width_reg = 512, height_reg = 512, gain_reg = 77;
   int unsigned in_r, in_c, out_r, out_c;
   bit          frame_done;

   px_result_type pending_px [$];
   int          fail_count = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          calm = 0;
   bit          burst_on = 1;
   bit          hold_go = 0;
   step_type    plan [$];

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // reflect-101 fold, then clamp into the image
   function automatic int unsigned fold(longint x, longint n);
      if (x < 0) x = -x;
      if (x >= n) x = 2 * n - 2 - x;
      if (x < 0) x = 0;
      if (x >= n) x = n - 1;
      return int'(x);
   endfunction

   function automatic void zero_pos();
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
   endfunction

   function automatic void csr_track(logic [1:0] idx, logic [12:0] data);
      case (idx)
         bbss_pkg::CSR_IMAGE_WIDTH:  width_reg  = data[9:0];
         bbss_pkg::CSR_IMAGE_HEIGHT: height_reg = data[12:0];
         bbss_pkg::CSR_GAIN_Q8:      gain_reg   = data[8:0];
         default: ;
      endcase
   endfunction

   function automatic void expect_add(input px_result_type r);
      pending_px = {pending_px, r};
   endfunction

   // Advances the predicted pixel pipeline by one transfer.
   function automatic void blur_predict(input logic typ, input logic [7:0] pix,
                                        output bit has, output px_result_type r);
      int unsigned w, h, sum, mean, src, rr, cc;
      longint total, lag, n, o, a, b, sh;
      has = 0;
      r = '0;
      w = clamp_u(width_reg, WIN, MAXW);
      h = clamp_u(height_reg, WIN, bbss_pkg::MAX_HEIGHT);
      total = longint'(w) * h;
      lag = longint'(PAD) * w + PAD;
      if (in_c >= w) begin in_c = 0; in_r++; end
      if (in_r > h) begin in_r = h; in_c = 0; end
      if (out_c >= w) begin out_c = 0; out_r++; end
      if (out_r >= h) begin
         zero_pos();
         return;
      end
      if (typ == bbss_pkg::REQ_PIXEL && in_r < h) begin
         line_mem[(in_r % WIN) * MAXW + in_c] = pix;
         in_c++;
         if (in_c >= w) begin in_c = 0; in_r++; end
      end
      n = longint'(in_r) * w + in_c;
      o = longint'(out_r) * w + out_c;
      if (!((n >= total && o < n) || (n - o > lag))) return;
      sum = 0;
      for (int dr = -PAD; dr <= PAD; dr++) begin
         rr = fold(longint'(out_r) + dr, h);
         for (int dc = -PAD; dc <= PAD; dc++) begin
            cc = fold(longint'(out_c) + dc, w);
            sum += line_mem[(rr % WIN) * MAXW + (cc % MAXW)];
         end
      end
      mean = sum / (WIN * WIN);
      if (mean > 255) mean = 255;
      src = line_mem[(out_r % WIN) * MAXW + (out_c % MAXW)];
      a = longint'(src) << FRAC;
      b = longint'(gain_reg) * mean;
      if (a <= b) sh = 0;
      else begin
         sh = (a - b) >>> FRAC;
         if (sh > 255) sh = 255;
      end
      has = 1;
      r.sharp = sh[7:0];
      r.blur = mean[7:0];
      r.last = (o == total - 1);
      if (r.last) begin
         zero_pos();
         frame_done = 1;
      end else begin
         out_c++;
         if (out_c >= w) begin out_c = 0; out_r++; end
      end
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [12:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_track(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one transfer on the request side, plus the matching expectation
   task automatic push_item(input logic typ, input logic [7:0] pix, input chk_type chk,
                            input px_result_type typed);
      bit has;
      px_result_type pr;
      int gap;
      req_valid <= 1'b1;
      req_type <= typ;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      blur_predict(typ, pix, has, pr);
      items_sent++;
      if (items_sent > 480) calm = 1;   // last part runs without idling
      if (items_sent % 64 == 0) burst_on = ($urandom_range(0, 3) != 0);
      if (has) begin
         if (chk == CHK_PRED) expect_add(pr);
         else if (chk == CHK_TYPED) expect_add(typed);
      end
      if (!calm && burst_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_px.size() != 0) @(posedge clock);
   endtask

   function automatic void add_row(row_kind_type kind, logic typ, int val, logic [1:0] idx,
                                   int cnt, bit rnd, chk_type chk, px_result_type typed);
      step_type s;
      s.kind = kind; s.typ = typ; s.val = val; s.idx = idx; s.cnt = cnt;
      s.rnd = rnd; s.chk = chk; s.typed = typed;
      plan = {plan, s};
   endfunction

   // response checker
   always @(posedge clock) begin
      px_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_px.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            e = pending_px.pop_front();
            if (rsp_sharp_pixel !== e.sharp) begin
               $error("sharp_pixel expected %0d got %0d", e.sharp, rsp_sharp_pixel);
               fail_count++;
            end
            if (rsp_blurred_pixel !== e.blur) begin
               $error("blurred_pixel expected %0d got %0d", e.blur, rsp_blurred_pixel);
               fail_count++;
            end
            if (rsp_frame_last !== e.last) begin
               $error("frame_last expected %0d got %0d", e.last, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off to back the block up
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 0;
            rsp_stall <= 1'b1;
            n = 0;
            while (n < 3000) begin
               @(posedge clock);
               n++;
            end
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus
   initial begin
      px_result_type none_r;
      int w, h, npx, frames;
      logic [7:0] pix;
      none_r = '0;
      for (int i = 0; i < WIN * MAXW; i++) line_mem[i] = 8'd0;
      zero_pos();

      // directed: smallest frame, gain extremes, constant frames with known results
      add_row(ROW_CSR, 0, 0, bbss_pkg::CSR_IMAGE_WIDTH, 1, 0, CHK_PRED, none_r);
      add_row(ROW_CSR, 0, 0, bbss_pkg::CSR_IMAGE_HEIGHT, 1, 0, CHK_PRED, none_r);
      add_row(ROW_CSR, 0, 0, bbss_pkg::CSR_GAIN_Q8, 1, 0, CHK_PRED, none_r);
      add_row(ROW_XFER, bbss_pkg::REQ_DRAIN, 0, 0, 1, 0, CHK_NONE, none_r);   // drain before input
      add_row(ROW_XFER, bbss_pkg::REQ_PIXEL, 255, 0, 121, 0, CHK_TYPED, '{8'd255, 8'd255, 1'b0});
      add_row(ROW_XFER, bbss_pkg::REQ_DRAIN, 0, 0, 59, 0, CHK_TYPED, '{8'd255, 8'd255, 1'b0});
      add_row(ROW_XFER, bbss_pkg::REQ_DRAIN, 0, 0, 1, 0, CHK_TYPED, '{8'd255, 8'd255, 1'b1});
      add_row(ROW_XFER, bbss_pkg::REQ_DRAIN, 0, 0, 2, 0, CHK_NONE, none_r);   // after frame end
      add_row(ROW_CSR, 0, 511, bbss_pkg::CSR_GAIN_Q8, 1, 0, CHK_PRED, none_r);
      add_row(ROW_XFER, bbss_pkg::REQ_PIXEL, 255, 0, 121, 0, CHK_TYPED, '{8'd0, 8'd255, 1'b0});
      // pixels past the frame's input act as drains
      add_row(ROW_XFER, bbss_pkg::REQ_PIXEL, 0, 0, 59, 0, CHK_TYPED, '{8'd0, 8'd255, 1'b0});
      add_row(ROW_XFER, bbss_pkg::REQ_PIXEL, 0, 0, 1, 0, CHK_TYPED, '{8'd0, 8'd255, 1'b1});
      add_row(ROW_CSR, 0, 77, bbss_pkg::CSR_GAIN_Q8, 1, 0, CHK_PRED, none_r);
      // register extremes (clamped); the random frames rewrite the sizes
      add_row(ROW_CSR, 0, 1023, bbss_pkg::CSR_IMAGE_WIDTH, 1, 0, CHK_PRED, none_r);
      add_row(ROW_CSR, 0, 8191, bbss_pkg::CSR_IMAGE_HEIGHT, 1, 0, CHK_PRED, none_r);

      @(negedge reset);
      @(posedge clock);
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (i == 0 || plan[i-1].kind != ROW_CSR) begin
               drain_results();
               repeat (SETTLE) @(posedge clock);
            end
            csr_write(plan[i].idx, plan[i].val[12:0]);
         end else begin
            for (int k = 0; k < plan[i].cnt; k++) begin
               pix = plan[i].rnd ? 8'($urandom_range(0, 255)) : plan[i].val[7:0];
               push_item(plan[i].typ, pix, plan[i].chk, plan[i].typed);
            end
         end
      end

      // random frames
      frames = 0;
      hold_go = 1;
      while (items_sent < 560) begin
         drain_results();
         repeat (SETTLE) @(posedge clock);
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 40) : $urandom_range(11, 20);
         h = $urandom_range(11, 13);
         csr_write(bbss_pkg::CSR_IMAGE_WIDTH, 13'(w));
         csr_write(bbss_pkg::CSR_IMAGE_HEIGHT, 13'(h));
         case ($urandom_range(0, 5))
            0: csr_write(bbss_pkg::CSR_GAIN_Q8, 13'd0);
            1: csr_write(bbss_pkg::CSR_GAIN_Q8, 13'd511);
            default: csr_write(bbss_pkg::CSR_GAIN_Q8, 13'($urandom_range(0, 511)));
         endcase
         frame_done = 0;
         npx = 0;
         while (npx < w * h) begin
            if ($urandom_range(0, 15) == 0) begin
               push_item(bbss_pkg::REQ_DRAIN, 8'($urandom_range(0, 255)), CHK_PRED, none_r);
            end else begin
               push_item(bbss_pkg::REQ_PIXEL, 8'($urandom_range(0, 255)), CHK_PRED, none_r);
               npx++;
            end
            // one mid-frame pause until the output side has caught up
            if (frames == 0 && npx == (w * h) / 2) drain_results();
         end
         while (!frame_done) begin
            push_item(($urandom_range(0, 7) == 0) ? bbss_pkg::REQ_PIXEL : bbss_pkg::REQ_DRAIN,
                      8'($urandom_range(0, 255)), CHK_PRED, none_r);
         end
         repeat ($urandom_range(0, 2))
            push_item(bbss_pkg::REQ_DRAIN, 8'($urandom_range(0, 255)), CHK_PRED, none_r);
         frames++;
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
